@@ rtl/core/sample_interval_statistics_top_defines.svh @@
// Assertion macros for the sample interval statistics block
`ifndef SAMPLE_INTERVAL_STATISTICS_TOP_DEFINES_SVH
`define SAMPLE_INTERVAL_STATISTICS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sis_pkg.sv @@
// Package: widths, codes and shared types of the sample interval statistics block
package sis_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int SAMPLE_BITS = 12;
   localparam int TOTAL_BITS  = 32;
   localparam int CHAN_BITS   = 3;
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int QUOT_BITS   = 2 * SAMPLE_BITS;
   localparam int STEP_BITS   = $clog2(QUOT_BITS);

   localparam int RES_BITS = COUNT_BITS + SUM_BITS + SQ_BITS + 3 * SAMPLE_BITS + COUNT_BITS
                             + SAMPLE_BITS + TOTAL_BITS + 1;
   localparam int RSP_DATA_BITS = ((RES_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS = 1 + CHAN_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL   = 1'b1;

   localparam logic ACT_ACCUMULATE = 1'b0;
   localparam logic ACT_REPORT     = 1'b1;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(2048);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX       = '1;

   typedef struct packed {
      logic accum;
      logic snap;
      logic div_step;
      logic mean_load;
      logic sqrt_load;
      logic sqrt_step;
      logic rms_store;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic                   overflowed;
      logic [TOTAL_BITS-1:0]  total_seen;
      logic [SAMPLE_BITS-1:0] rms_value;
      logic [SAMPLE_BITS-1:0] mean_value;
      logic [COUNT_BITS-1:0]  crossings;
      logic [SAMPLE_BITS-1:0] maximum;
      logic [SAMPLE_BITS-1:0] minimum;
      logic [SQ_BITS-1:0]     square_sum;
      logic [SUM_BITS-1:0]    sample_sum;
      logic [COUNT_BITS-1:0]  num_samples;
   } result_type;

endpackage

@@ rtl/core/sis_ctrl.sv @@
// Controller: accepts words, sequences the report divisions, square root and output load
module sis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_action,
   input  sis_pkg::status_type status,
   output logic                req_tready,
   output sis_pkg::cmd_type    cmd
);
   import sis_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DIV_SQ   = 5'b00010,
      ST_DIV_MEAN = 5'b00100,
      ST_SQRT     = 5'b01000,
      ST_HOLD     = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  last_step;

   assign last_step  = (step_ff == '0);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_action == ACT_REPORT) begin
                  if (!status.empty) begin
                     cmd.snap = 1'b1;
                     step_in  = STEP_BITS'(QUOT_BITS - 1);
                     state_in = ST_DIV_SQ;
                  end
               end else begin
                  cmd.accum = 1'b1;
               end
            end
         end
         ST_DIV_SQ: begin
            cmd.div_step = 1'b1;
            if (last_step) begin
               cmd.mean_load = 1'b1;
               step_in       = STEP_BITS'(SAMPLE_BITS - 1);
               state_in      = ST_DIV_MEAN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            if (last_step) begin
               cmd.sqrt_load = 1'b1;
               step_in       = STEP_BITS'(SAMPLE_BITS - 1);
               state_in      = ST_SQRT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (last_step) begin
               cmd.rms_store = 1'b1;
               state_in      = ST_HOLD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/core/sis_datapath.sv @@
// Datapath: config registers, interval accumulators, shared divider, square root, output word
module sis_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sis_pkg::cmd_type                       cmd,
   output sis_pkg::status_type                    status,
   input  logic [sis_pkg::CHAN_BITS-1:0]          req_channel,
   input  logic [sis_pkg::SAMPLE_BITS-1:0]        req_sample,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [sis_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [sis_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tvalid,
   output sis_pkg::result_type                    result
);
   import sis_pkg::*;

   // configuration
   logic [SAMPLE_BITS-1:0] thr_ff;
   logic [CHAN_BITS-1:0]   sel_ff;

   // live interval
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SQ_BITS-1:0]     sq_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [COUNT_BITS-1:0]  crs_ff;
   logic                   high_ff;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic                   ovf_ff;

   // report snapshot
   logic [COUNT_BITS-1:0]  snap_cnt_ff;
   logic [SUM_BITS-1:0]    snap_sum_ff;
   logic [SQ_BITS-1:0]     snap_sq_ff;
   logic [SAMPLE_BITS-1:0] snap_min_ff;
   logic [SAMPLE_BITS-1:0] snap_max_ff;
   logic [COUNT_BITS-1:0]  snap_crs_ff;
   logic [TOTAL_BITS-1:0]  snap_total_ff;
   logic                   snap_ovf_ff;

   // restoring divider, one quotient bit per cycle
   logic [SQ_BITS-1:0]     rem_ff, rem_in;
   logic [SQ_BITS-1:0]     dsh_ff;
   logic [QUOT_BITS-1:0]   q_ff, q_in;
   logic [QUOT_BITS-1:0]   qbit_ff;

   // square root, one root bit per cycle
   logic [QUOT_BITS-1:0]   sqq_ff;
   logic [SAMPLE_BITS-1:0] root_ff, root_in;
   logic [SAMPLE_BITS-1:0] rbit_ff;
   logic [SAMPLE_BITS-1:0] trial;
   logic [QUOT_BITS-1:0]   trial_sq;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [SAMPLE_BITS-1:0] rms_ff;

   // output word
   result_type             out_ff;
   logic                   valid_ff;

   logic                   take;
   logic                   high;
   logic [QUOT_BITS-1:0]   square;

   assign take   = cmd.accum && (req_channel == sel_ff);
   assign high   = (req_sample >= thr_ff);
   assign square = {{SAMPLE_BITS{1'b0}}, req_sample} * {{SAMPLE_BITS{1'b0}}, req_sample};

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      if (dsh_ff <= rem_ff) begin
         rem_in = rem_ff - dsh_ff;
         q_in   = q_ff | qbit_ff;
      end
   end

   assign trial    = root_ff | rbit_ff;
   assign trial_sq = {{SAMPLE_BITS{1'b0}}, trial} * {{SAMPLE_BITS{1'b0}}, trial};
   assign root_in  = (trial_sq <= sqq_ff) ? trial : root_ff;

   assign status.empty    = (cnt_ff == '0);
   assign status.out_free = !valid_ff || rsp_tready;
   assign rsp_tvalid      = valid_ff;
   assign result          = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         sel_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_CHANNEL:   sel_ff <= csr_data[CHAN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         crs_ff   <= '0;
         high_ff  <= 1'b0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.snap) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         min_ff <= '1;
         max_ff <= '0;
         crs_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         if (cnt_ff == COUNT_MAX) begin
            ovf_ff <= 1'b1;
         end else begin
            cnt_ff   <= cnt_ff + 1'b1;
            total_ff <= total_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_BITS'(req_sample);
            sq_ff    <= sq_ff + SQ_BITS'(square);
            if (req_sample < min_ff) min_ff <= req_sample;
            if (req_sample > max_ff) max_ff <= req_sample;
            if (high != high_ff) crs_ff <= crs_ff + 1'b1;
            high_ff <= high;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         snap_cnt_ff   <= cnt_ff;
         snap_sum_ff   <= sum_ff;
         snap_sq_ff    <= sq_ff;
         snap_min_ff   <= min_ff;
         snap_max_ff   <= max_ff;
         snap_crs_ff   <= crs_ff;
         snap_total_ff <= total_ff;
         snap_ovf_ff   <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         rem_ff  <= sq_ff;
         dsh_ff  <= {{(SQ_BITS-COUNT_BITS){1'b0}}, cnt_ff} << (QUOT_BITS - 1);
         q_ff    <= '0;
         qbit_ff <= QUOT_BITS'(1) << (QUOT_BITS - 1);
      end else if (cmd.mean_load) begin
         rem_ff  <= {{(SQ_BITS-SUM_BITS){1'b0}}, snap_sum_ff};
         dsh_ff  <= {{(SQ_BITS-COUNT_BITS){1'b0}}, snap_cnt_ff} << (SAMPLE_BITS - 1);
         q_ff    <= '0;
         qbit_ff <= QUOT_BITS'(1) << (SAMPLE_BITS - 1);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_ff >> 1;
         q_ff    <= q_in;
         qbit_ff <= qbit_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mean_load) sqq_ff <= q_in;
      if (cmd.sqrt_load) begin
         mean_ff <= q_in[SAMPLE_BITS-1:0];
         root_ff <= '0;
         rbit_ff <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
      end else if (cmd.sqrt_step) begin
         root_ff <= root_in;
         rbit_ff <= rbit_ff >> 1;
      end
      if (cmd.rms_store) rms_ff <= root_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.num_samples  <= snap_cnt_ff;
         out_ff.sample_sum   <= snap_sum_ff;
         out_ff.square_sum   <= snap_sq_ff;
         out_ff.minimum      <= snap_min_ff;
         out_ff.maximum      <= snap_max_ff;
         out_ff.crossings    <= snap_crs_ff;
         out_ff.mean_value   <= mean_ff;
         out_ff.rms_value    <= rms_ff;
         out_ff.total_seen   <= snap_total_ff;
         out_ff.overflowed   <= snap_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

@@ rtl/core/sample_interval_statistics_top.sv @@
// Top level: interval statistics over a tagged ADC sample stream
//
//   channel  dir   handshake              payload
//   req      in    req_tvalid/req_tready  tdata: sample; tuser: action, channel
//   rsp      out   rsp_tvalid/rsp_tready  tdata: interval figures, mean, rms, totals
//   csr      in    csr_valid/csr_ready    csr_index, csr_data
//
// One accumulate word may be taken in every cycle while no report is in progress.
// A report word on a non-empty interval holds req_tready low until its result is loaded:
// 1 snapshot, 24 divider steps for the square mean, 12 for the mean,
// 12 square root steps, 1 output load; divider and root resolve one bit per cycle.
// A stalled rsp word does not block accumulates; a further report waits before loading it.
// Reset is synchronous, active high; csr_ready is always high.
module sample_interval_statistics_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sis_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // sample_value
   input  logic [sis_pkg::REQ_USER_BITS-1:0]   req_tuser,  // action, channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // num_samples, sample_sum, square_sum, minimum, maximum, crossings,
   // mean_value, rms_value, total_seen, overflowed
   output logic [sis_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sis_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sis_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sis_pkg::*;

`include "sample_interval_statistics_top_defines.svh"

   cmd_type    ctl_cmd;
   status_type dp_status;
   result_type result;

   assign csr_ready = 1'b1;

   sis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[0]),
      .status     (dp_status),
      .req_tready (req_tready),
      .cmd        (ctl_cmd)
   );

   sis_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctl_cmd),
      .status      (dp_status),
      .req_channel (req_tuser[CHAN_BITS:1]),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .result      (result)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-RES_BITS){1'b0}}, result};

   `SIS_ASSERT_NEXT(a_busy_after_report, ctl_cmd.snap, !req_tready, "ready after report start")
   `SIS_ASSERT_NOW(a_load_when_free, ctl_cmd.out_load, !rsp_tvalid || rsp_tready, "result overwritten")
   `SIS_ASSERT_NOW(a_rise_from_load, $rose(rsp_tvalid), $past(ctl_cmd.out_load), "stray result")
   `SIS_ASSERT_NOW(a_count_nonzero, rsp_tvalid, result.num_samples != '0, "empty interval reported")

endmodule

@@ tb/tb.sv @@
// Testbench for sample_interval_statistics_top: random stream words checked against a predictor
module tb;
   import sis_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_PCT     = 21;

   class interval_scoreboard;
      logic [SAMPLE_BITS-1:0] threshold;
      logic [CHAN_BITS-1:0]   chan_sel;
      logic [COUNT_BITS-1:0]  count;
      logic [SUM_BITS-1:0]    sum;
      logic [SQ_BITS-1:0]     sq_sum;
      logic [SAMPLE_BITS-1:0] min_val;
      logic [SAMPLE_BITS-1:0] max_val;
      logic [COUNT_BITS-1:0]  crossings;
      logic                   last_high;
      logic [TOTAL_BITS-1:0]  total;
      logic                   overflow;
      result_type             pending_reports[$];
      int                     errors;

      function new();
         threshold = THRESHOLD_RESET;
         chan_sel  = '0;
         last_high = 1'b0;
         total     = '0;
         errors    = 0;
         clear_interval();
      endfunction

      function void clear_interval();
         count     = '0;
         sum       = '0;
         sq_sum    = '0;
         min_val   = '1;
         max_val   = '0;
         crossings = '0;
         overflow  = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         if (index == CSR_THRESHOLD) begin
            threshold = data[SAMPLE_BITS-1:0];
         end else if (index == CSR_CHANNEL) begin
            chan_sel = data[CHAN_BITS-1:0];
         end
      endfunction

      function logic [SAMPLE_BITS-1:0] floor_root(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root[SAMPLE_BITS-1:0];
      endfunction

      function void note_word(logic act, logic [CHAN_BITS-1:0] chan, logic [SAMPLE_BITS-1:0] s);
         result_type r;
         logic       high;
         if (act == ACT_ACCUMULATE) begin
            if (chan != chan_sel) return;
            if (count >= COUNT_MAX) begin
               overflow = 1'b1;
               return;
            end
            count  = count + 1'b1;
            total  = total + 1'b1;
            sum    = sum + SUM_BITS'(s);
            sq_sum = sq_sum + SQ_BITS'(s) * SQ_BITS'(s);
            if (s < min_val) min_val = s;
            if (s > max_val) max_val = s;
            high = (s >= threshold);
            if (high != last_high) crossings = crossings + 1'b1;
            last_high = high;
            return;
         end
         if (count == '0) return;
         r.num_samples  = count;
         r.sample_sum   = sum;
         r.square_sum   = sq_sum;
         r.minimum      = min_val;
         r.maximum      = max_val;
         r.crossings    = crossings;
         r.mean_value   = SAMPLE_BITS'(64'(sum) / 64'(count));
         r.rms_value    = floor_root(64'(sq_sum) / 64'(count));
         r.total_seen   = total;
         r.overflowed   = overflow;
         pending_reports.push_back(r);
         clear_interval();
      endfunction

      function void compare_field(string label, longint unsigned exp, longint unsigned got);
         if (exp != got) begin
            $error("%s: expected %0d, got %0d", label, exp, got);
            errors++;
         end
      endfunction

      function void check_report(result_type got);
         result_type exp;
         if (pending_reports.size() == 0) begin
            $error("unexpected rsp word: num_samples %0d", got.num_samples);
            errors++;
            return;
         end
         exp = pending_reports.pop_front();
         compare_field("num_samples", exp.num_samples, got.num_samples);
         compare_field("sample_sum", exp.sample_sum, got.sample_sum);
         compare_field("square_sum", exp.square_sum, got.square_sum);
         compare_field("minimum", exp.minimum, got.minimum);
         compare_field("maximum", exp.maximum, got.maximum);
         compare_field("crossings", exp.crossings, got.crossings);
         compare_field("mean_value", exp.mean_value, got.mean_value);
         compare_field("rms_value", exp.rms_value, got.rms_value);
         compare_field("total_seen", exp.total_seen, got.total_seen);
         compare_field("overflowed", exp.overflowed, got.overflowed);
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic [REQ_USER_BITS-1:0]  req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   interval_scoreboard sb = new();
   bit                 calm = 1'b0;
   int                 cycles = 0;

   sample_interval_statistics_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_report(result_type'(rsp_tdata[RES_BITS-1:0]));
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_word(logic act, logic [CHAN_BITS-1:0] chan, logic [SAMPLE_BITS-1:0] s);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(s);
      req_tuser  <= {chan, act};
      do @(posedge clock); while (!req_tready);
      sb.note_word(act, chan, s);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] thr);
      int pick;
      int v;
      pick = $urandom_range(7);
      if (pick < 2) begin
         v = int'(thr) + $urandom_range(8) - 4;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return SAMPLE_BITS'(v);
      end
      if (pick == 2) return $urandom_range(1) ? '1 : '0;
      return SAMPLE_BITS'($urandom_range(4095));
   endfunction

   // n counts report words and accumulate words on the selected channel
   task automatic run_random(int n, int report_pct);
      int                   done;
      logic [CHAN_BITS-1:0] chan;
      done = 0;
      while (done < n) begin
         if ($urandom_range(99) < report_pct) begin
            send_word(ACT_REPORT, CHAN_BITS'($urandom_range(7)),
                      SAMPLE_BITS'($urandom_range(4095)));
            done++;
         end else begin
            chan = ($urandom_range(99) < 15) ? CHAN_BITS'($urandom_range(7)) : sb.chan_sel;
            send_word(ACT_ACCUMULATE, chan, pick_sample(sb.threshold));
            if (chan == sb.chan_sel) done++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: threshold 2048, channel 0
      send_word(ACT_REPORT, 3'd0, 12'd0);           // empty interval
      send_word(ACT_ACCUMULATE, 3'd0, 12'd0);
      send_word(ACT_ACCUMULATE, 3'd0, 12'd4095);
      send_word(ACT_ACCUMULATE, 3'd0, 12'd2048);
      send_word(ACT_ACCUMULATE, 3'd0, 12'd2047);
      send_word(ACT_ACCUMULATE, 3'd5, 12'd4095);    // other channel
      send_word(ACT_REPORT, 3'd7, 12'hFFF);
      send_word(ACT_REPORT, 3'd0, 12'd0);
      send_word(ACT_ACCUMULATE, 3'd0, 12'd4095);    // low to high across a report
      send_word(ACT_REPORT, 3'd2, 12'd0);
      send_word(ACT_ACCUMULATE, 3'd0, 12'hAAA);
      send_word(ACT_ACCUMULATE, 3'd0, 12'h555);
      for (int c = 1; c < 8; c++) begin
         send_word(ACT_ACCUMULATE, CHAN_BITS'(c), SAMPLE_BITS'($urandom_range(4095)));
      end
      send_word(ACT_REPORT, 3'd0, 12'd0);
      settle();

      write_reg(CSR_THRESHOLD, 12'd0);
      write_reg(CSR_CHANNEL, CSR_DATA_BITS'(7));
      run_random(180, 8);
      settle();

      write_reg(CSR_THRESHOLD, 12'd4095);
      write_reg(CSR_CHANNEL, CSR_DATA_BITS'(0));
      calm = 1'b1;
      run_random(180, 8);
      calm = 1'b0;
      settle();

      write_reg(CSR_THRESHOLD, 12'd2048);
      write_reg(CSR_CHANNEL, CSR_DATA_BITS'(3));
      run_random(190, 2);
      settle();

      write_reg(CSR_THRESHOLD, CSR_DATA_BITS'($urandom_range(4095)));
      write_reg(CSR_CHANNEL, CSR_DATA_BITS'($urandom_range(7)));
      run_random(180, 8);
      settle();

      write_reg(CSR_THRESHOLD, 12'd1);
      write_reg(CSR_CHANNEL, CSR_DATA_BITS'(4));
      run_random(180, 15);
      settle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
